FILE: design/ahrfp_pkg.sv
// Shared types, constants and helper functions of the ASCII hex reading frame parser.
`default_nettype none

package ahrfp_pkg;

    // Frame layout: byte positions within one frame.
    localparam int unsigned FRAME_LEN      = 16;
    localparam int unsigned COUNT_W        = 5;
    localparam logic [4:0]  COUNT_MAX      = 5'd31;
    localparam logic [4:0]  POS_HDR_STAR   = 5'd0;
    localparam logic [4:0]  POS_HDR_C      = 5'd1;
    localparam logic [4:0]  POS_HDR_F      = 5'd2;
    localparam logic [4:0]  POS_HDR_V      = 5'd3;
    localparam logic [4:0]  POS_ADDR_TENS  = 5'd4;
    localparam logic [4:0]  POS_ADDR_UNITS = 5'd5;
    localparam logic [4:0]  POS_CSUM_FIRST = 5'd12;
    localparam logic [4:0]  POS_CR         = 5'd14;
    localparam logic [4:0]  POS_LF         = 5'd15;
    localparam logic [4:0]  POS_FRAME_LEN  = 5'(FRAME_LEN);

    // Characters that the frame must carry.
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_F    = 8'h46;
    localparam logic [7:0] CHAR_V    = 8'h56;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;

    // Field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ADDR_W   = 7;
    localparam int unsigned VALUE_W  = 24;
    localparam int unsigned STATUS_W = 3;

    // Register map.
    localparam int unsigned PADDR_W     = 3;
    localparam logic [0:0]  REG_DEV_ADDR = 1'b0;

    // Result status codes.
    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_LEN   = 3'd1,
        STATUS_BAD_FMT   = 3'd2,
        STATUS_BAD_CSUM  = 3'd3,
        STATUS_BAD_HEX   = 3'd4
    } frame_status_t;

    // Decodes one ASCII hex digit; bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        case (c) inside
            [8'h30:8'h39]: r = {1'b0, c[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: r = {1'b0, c[3:0] + 4'd9};
            default:       r = 5'h10;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/ascii_hex_reading_frame_parser.sv
// Top level of the ASCII hex reading frame parser: input register, frame checks, result register.
//
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | s_rx_byte, s_end_of_frame
//  m_      | out       | m_valid / m_ready  | m_frame_status, m_level_value
//  APB     | in        | psel/penable/pready| paddr, pwdata, prdata (device_address)
//
// One byte is taken every cycle unless the input register holds back; a byte passes through the
// input register, and the result of a frame-ending byte is then loaded into the result register.
// The input register only holds back when it carries a frame-ending byte while an earlier
// result is still waiting and m_ready is low; other bytes always pass on.
// Reset (aresetn low, synchronous) empties both registers and clears all frame state,
// the held value and device_address.
`default_nettype none

module ascii_hex_reading_frame_parser (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ahrfp_pkg::BYTE_W-1:0]        s_rx_byte,
    input  wire logic                                s_end_of_frame,
    // Result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ahrfp_pkg::STATUS_W-1:0]           m_frame_status,
    output logic [ahrfp_pkg::VALUE_W-1:0]            m_level_value,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ahrfp_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    // Configuration register.
    logic [ahrfp_pkg::ADDR_W-1:0] dev_addr_reg;

    // Input register.
    logic                         in_valid_reg;
    logic [ahrfp_pkg::BYTE_W-1:0] in_byte_reg;
    logic                         in_eof_reg;

    // Frame state.
    logic [ahrfp_pkg::COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]                    running_sum_reg, running_sum_next;
    logic [ahrfp_pkg::VALUE_W-1:0] value_acc_reg, value_acc_next;
    logic [7:0]                    rx_csum_reg, rx_csum_next;
    logic                          format_good_reg, format_good_next;
    logic                          hex_good_reg, hex_good_next;
    logic [ahrfp_pkg::VALUE_W-1:0] held_value_reg, held_value_next;

    // Result register.
    logic                          out_valid_reg;
    ahrfp_pkg::frame_status_t      out_status_reg, out_status_next;

    logic       proc_fire;
    logic       in_advance;
    logic       cfg_write;
    logic [4:0] hex_dec;
    logic       in_frame;
    logic [14:0] tens_prod;
    logic [3:0]  addr_tens;
    logic [6:0]  addr_units_wide;
    logic [7:0]  exp_tens_char;
    logic [7:0]  exp_units_char;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // APB write and read of device_address; the word index is paddr bit 2.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= '0;
        end else if (cfg_write && (paddr[2] == ahrfp_pkg::REG_DEV_ADDR)) begin
            dev_addr_reg <= pwdata[ahrfp_pkg::ADDR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ahrfp_pkg::REG_DEV_ADDR) begin
            prdata = {{(32-ahrfp_pkg::ADDR_W){1'b0}}, dev_addr_reg};
        end
    end

    // Expected address characters; divide by ten through multiplication by 205/2048.
    assign tens_prod       = {8'd0, dev_addr_reg} * 15'd205;
    assign addr_tens       = tens_prod[14:11];
    assign addr_units_wide = dev_addr_reg - ({3'd0, addr_tens} * 7'd10);
    assign exp_tens_char   = ahrfp_pkg::CHAR_ZERO + {4'd0, addr_tens};
    assign exp_units_char  = ahrfp_pkg::CHAR_ZERO + {4'd0, addr_units_wide[3:0]};

    // Flow control: only a frame-ending item needs room in the result register.
    assign in_advance = !in_eof_reg || !out_valid_reg || m_ready;
    assign proc_fire  = in_valid_reg && in_advance;
    assign s_ready    = !in_valid_reg || in_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_eof_reg  <= s_end_of_frame;
        end
    end

    // Per-byte checks and accumulation for the byte in the input register.
    assign hex_dec  = ahrfp_pkg::hex_decode(in_byte_reg);
    assign in_frame = byte_count_reg < ahrfp_pkg::POS_FRAME_LEN;

    always_comb begin
        running_sum_next = running_sum_reg;
        value_acc_next   = value_acc_reg;
        rx_csum_next     = rx_csum_reg;
        format_good_next = format_good_reg;
        hex_good_next    = hex_good_reg;

        if (in_frame && (byte_count_reg < ahrfp_pkg::POS_CSUM_FIRST)) begin
            running_sum_next = running_sum_reg + in_byte_reg;
        end

        case (byte_count_reg)
            ahrfp_pkg::POS_HDR_STAR: begin
                if (in_byte_reg != ahrfp_pkg::CHAR_STAR) format_good_next = 1'b0;
            end
            ahrfp_pkg::POS_HDR_C: begin
                if (in_byte_reg != ahrfp_pkg::CHAR_C) format_good_next = 1'b0;
            end
            ahrfp_pkg::POS_HDR_F: begin
                if (in_byte_reg != ahrfp_pkg::CHAR_F) format_good_next = 1'b0;
            end
            ahrfp_pkg::POS_HDR_V: begin
                if (in_byte_reg != ahrfp_pkg::CHAR_V) format_good_next = 1'b0;
            end
            ahrfp_pkg::POS_ADDR_TENS: begin
                if (in_byte_reg != exp_tens_char) format_good_next = 1'b0;
            end
            ahrfp_pkg::POS_ADDR_UNITS: begin
                if (in_byte_reg != exp_units_char) format_good_next = 1'b0;
            end
            ahrfp_pkg::POS_CR: begin
                if (in_byte_reg != ahrfp_pkg::CHAR_CR) format_good_next = 1'b0;
            end
            ahrfp_pkg::POS_LF: begin
                if (in_byte_reg != ahrfp_pkg::CHAR_LF) format_good_next = 1'b0;
            end
            default: begin
                // Value and checksum digits; bytes past the frame length are not examined.
                if (in_frame) begin
                    if (hex_dec[4]) hex_good_next = 1'b0;
                    if (byte_count_reg < ahrfp_pkg::POS_CSUM_FIRST) begin
                        value_acc_next = {value_acc_reg[ahrfp_pkg::VALUE_W-5:0],
                                          hex_dec[4] ? 4'd0 : hex_dec[3:0]};
                    end else begin
                        rx_csum_next = {rx_csum_reg[3:0], hex_dec[4] ? 4'd0 : hex_dec[3:0]};
                    end
                end
            end
        endcase

        if (byte_count_reg == ahrfp_pkg::COUNT_MAX) begin
            byte_count_next = byte_count_reg;
        end else begin
            byte_count_next = byte_count_reg + 5'd1;
        end
    end

    // Frame verdict, in priority order.
    always_comb begin
        held_value_next = held_value_reg;
        if (byte_count_next != ahrfp_pkg::POS_FRAME_LEN) begin
            out_status_next = ahrfp_pkg::STATUS_BAD_LEN;
        end else if (!format_good_next) begin
            out_status_next = ahrfp_pkg::STATUS_BAD_FMT;
        end else if (!hex_good_next) begin
            out_status_next = ahrfp_pkg::STATUS_BAD_HEX;
        end else if (rx_csum_next != running_sum_next) begin
            out_status_next = ahrfp_pkg::STATUS_BAD_CSUM;
        end else begin
            out_status_next = ahrfp_pkg::STATUS_OK;
            held_value_next = value_acc_next;
        end
    end

    // Frame state update; a frame-ending item returns the frame state to its start.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            value_acc_reg   <= '0;
            rx_csum_reg     <= '0;
            format_good_reg <= 1'b1;
            hex_good_reg    <= 1'b1;
            held_value_reg  <= '0;
        end else if (proc_fire) begin
            if (in_eof_reg) begin
                byte_count_reg  <= '0;
                running_sum_reg <= '0;
                value_acc_reg   <= '0;
                rx_csum_reg     <= '0;
                format_good_reg <= 1'b1;
                hex_good_reg    <= 1'b1;
                held_value_reg  <= held_value_next;
            end else begin
                byte_count_reg  <= byte_count_next;
                running_sum_reg <= running_sum_next;
                value_acc_reg   <= value_acc_next;
                rx_csum_reg     <= rx_csum_next;
                format_good_reg <= format_good_next;
                hex_good_reg    <= hex_good_next;
            end
        end
    end

    // Result register; the held value only changes when a new result is loaded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && in_eof_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && in_eof_reg) begin
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_status = out_status_reg;
    assign m_level_value  = held_value_reg;

endmodule

`default_nettype wire

FILE: design/ahrfp_checker.sv
// Port-level checks of the ASCII hex reading frame parser and the bind that attaches them.
`default_nettype none

module ahrfp_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [ahrfp_pkg::STATUS_W-1:0]    m_frame_status,
    input wire logic [ahrfp_pkg::VALUE_W-1:0]     m_level_value,
    input wire logic                              pready
);

    // A result that waits keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level_value) && $stable(m_frame_status))
        else $error("result changed while waiting");

    // Input is held back only by a waiting, untaken result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only defined status codes are reported.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_status <= 3'(ahrfp_pkg::STATUS_BAD_HEX))
        else $error("undefined frame status");

    // The configuration port never inserts wait states.
    assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind ascii_hex_reading_frame_parser ahrfp_checker u_ahrfp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_frame_status (m_frame_status),
    .m_level_value  (m_level_value),
    .pready         (pready)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench of the ASCII hex reading frame parser, with directed and random frames.

module testbench;

    typedef logic [ahrfp_pkg::PADDR_W-1:0] paddr_t;
    typedef logic [ahrfp_pkg::ADDR_W-1:0]  addr_t;
    typedef logic [ahrfp_pkg::VALUE_W-1:0] value_t;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int IDLE_PCT      = 34;
    localparam int SETTLE_CYCLES = 4;
    localparam paddr_t DEV_ADDR_OFFSET = paddr_t'(4 * ahrfp_pkg::REG_DEV_ADDR);
    localparam paddr_t SPARE_OFFSET    = paddr_t'(4);

    typedef struct {
        ahrfp_pkg::frame_status_t status;
        value_t                   level;
    } frame_result_t;

    // Clock, reset and stimulus towards the block.
    logic                              aclk           = 1'b0;
    logic                              aresetn        = 1'b0;
    logic                              s_valid        = 1'b0;
    logic [ahrfp_pkg::BYTE_W-1:0]      s_rx_byte      = '0;
    logic                              s_end_of_frame = 1'b0;
    logic                              m_ready        = 1'b0;
    logic                              psel           = 1'b0;
    logic                              penable        = 1'b0;
    logic                              pwrite         = 1'b0;
    paddr_t                            paddr          = '0;
    logic [31:0]                       pwdata         = '0;

    // Outputs of the block.
    logic                              s_ready;
    logic                              m_valid;
    logic [ahrfp_pkg::STATUS_W-1:0]    m_frame_status;
    value_t                            m_level_value;
    logic [31:0]                       prdata;
    logic                              pready;

    // Predicted parser state and configuration.
    addr_t                             dev_addr = '0;
    logic [ahrfp_pkg::COUNT_W-1:0]     frame_pos = '0;
    logic [7:0]                        byte_sum = '0;
    value_t                            value_acc = '0;
    logic [7:0]                        csum_digits = '0;
    logic                              layout_ok = 1'b1;
    logic                              digits_ok = 1'b1;
    value_t                            held_level = '0;

    frame_result_t        frame_results_due[$];
    logic [7:0]           frame_buf[$];
    int                   mismatches = 0;
    int                   cycles = 0;
    bit                   idle_on = 1'b1;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    ascii_hex_reading_frame_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_status (m_frame_status),
        .m_level_value  (m_level_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Guard against a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** ascii_hex_reading_frame_parser: FAILED **");
            $finish;
        end
    end

    // The result side stalls at random unless idling is switched off.
    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Each accepted result is compared with the oldest predicted one.
    always @(posedge aclk) begin
        frame_result_t due;
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                $display("%0t: result with none expected: status %0d, level %06h",
                         $time, m_frame_status, m_level_value);
                mismatches++;
            end else begin
                due = frame_results_due.pop_front();
                if (m_frame_status !== due.status) begin
                    $display("%0t: frame_status expected %0d, actual %0d",
                             $time, due.status, m_frame_status);
                    mismatches++;
                end
                if (m_level_value !== due.level) begin
                    $display("%0t: level_value expected %06h, actual %06h",
                             $time, due.level, m_level_value);
                    mismatches++;
                end
            end
        end
    end

    // Value of one hex character, or 16 where the character is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        return 5'd16;
    endfunction

    // Hex character of one nibble, letters in either case at random.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return ahrfp_pkg::CHAR_ZERO + 8'(n);
        return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(n - 4'd10);
    endfunction

    // Advances the predicted frame state by one byte and, at a frame end, queues its result.
    task automatic predict_frame_byte(input logic [7:0] b, input logic eof);
        logic [4:0]    nib;
        frame_result_t r;
        if (frame_pos < ahrfp_pkg::POS_FRAME_LEN) begin
            if (frame_pos < ahrfp_pkg::POS_CSUM_FIRST) byte_sum = byte_sum + b;
            case (frame_pos)
                ahrfp_pkg::POS_HDR_STAR:
                    if (b != ahrfp_pkg::CHAR_STAR) layout_ok = 1'b0;
                ahrfp_pkg::POS_HDR_C:
                    if (b != ahrfp_pkg::CHAR_C) layout_ok = 1'b0;
                ahrfp_pkg::POS_HDR_F:
                    if (b != ahrfp_pkg::CHAR_F) layout_ok = 1'b0;
                ahrfp_pkg::POS_HDR_V:
                    if (b != ahrfp_pkg::CHAR_V) layout_ok = 1'b0;
                ahrfp_pkg::POS_ADDR_TENS:
                    if (b != ahrfp_pkg::CHAR_ZERO + 8'(dev_addr / 7'd10)) layout_ok = 1'b0;
                ahrfp_pkg::POS_ADDR_UNITS:
                    if (b != ahrfp_pkg::CHAR_ZERO + 8'(dev_addr % 7'd10)) layout_ok = 1'b0;
                ahrfp_pkg::POS_CR:
                    if (b != ahrfp_pkg::CHAR_CR) layout_ok = 1'b0;
                ahrfp_pkg::POS_LF:
                    if (b != ahrfp_pkg::CHAR_LF) layout_ok = 1'b0;
                default: begin
                    nib = hex_value(b);
                    if (nib[4]) begin
                        digits_ok = 1'b0;
                        nib = '0;
                    end
                    if (frame_pos < ahrfp_pkg::POS_CSUM_FIRST)
                        value_acc = {value_acc[ahrfp_pkg::VALUE_W-5:0], nib[3:0]};
                    else
                        csum_digits = {csum_digits[3:0], nib[3:0]};
                end
            endcase
        end
        if (frame_pos != ahrfp_pkg::COUNT_MAX) frame_pos = frame_pos + 1'b1;

        if (eof) begin
            // Length first, then layout, then digits, then the checksum.
            if (frame_pos != ahrfp_pkg::POS_FRAME_LEN) r.status = ahrfp_pkg::STATUS_BAD_LEN;
            else if (!layout_ok) r.status = ahrfp_pkg::STATUS_BAD_FMT;
            else if (!digits_ok) r.status = ahrfp_pkg::STATUS_BAD_HEX;
            else if (csum_digits != byte_sum) r.status = ahrfp_pkg::STATUS_BAD_CSUM;
            else begin
                r.status = ahrfp_pkg::STATUS_OK;
                held_level = value_acc;
            end
            r.level = held_level;
            frame_results_due.push_back(r);
            frame_pos   = '0;
            byte_sum    = '0;
            value_acc   = '0;
            csum_digits = '0;
            layout_ok   = 1'b1;
            digits_ok   = 1'b1;
        end
    endtask

    // Offers one item, with random gaps, and predicts it once accepted.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_rx_byte      <= b;
        s_end_of_frame <= eof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_frame_byte(b, eof);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Builds a well-formed frame for the current address and the given value.
    task automatic build_frame(input value_t value);
        logic [7:0] sum;
        frame_buf.delete();
        frame_buf.push_back(ahrfp_pkg::CHAR_STAR);
        frame_buf.push_back(ahrfp_pkg::CHAR_C);
        frame_buf.push_back(ahrfp_pkg::CHAR_F);
        frame_buf.push_back(ahrfp_pkg::CHAR_V);
        frame_buf.push_back(ahrfp_pkg::CHAR_ZERO + 8'(dev_addr / 7'd10));
        frame_buf.push_back(ahrfp_pkg::CHAR_ZERO + 8'(dev_addr % 7'd10));
        for (int i = 5; i >= 0; i--) frame_buf.push_back(hex_char(value[4*i +: 4]));
        sum = '0;
        foreach (frame_buf[i]) sum = sum + frame_buf[i];
        frame_buf.push_back(hex_char(sum[7:4]));
        frame_buf.push_back(hex_char(sum[3:0]));
        frame_buf.push_back(ahrfp_pkg::CHAR_CR);
        frame_buf.push_back(ahrfp_pkg::CHAR_LF);
    endtask

    // Lets every expected result arrive and the pipeline empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register access: a setup phase, then an access phase.
    task automatic reg_access(input logic wr, input paddr_t addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (wr && addr == DEV_ADDR_OFFSET) dev_addr = data[ahrfp_pkg::ADDR_W-1:0];
        if (!wr && prdata[ahrfp_pkg::ADDR_W-1:0] !== dev_addr) begin
            $display("%0t: device_address read expected %0d, actual %0d",
                     $time, dev_addr, prdata[ahrfp_pkg::ADDR_W-1:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes a register while the block is idle, then reads the address back.
    task automatic set_address(input paddr_t addr, input logic [31:0] data);
        settle();
        reg_access(1'b1, addr, data);
        reg_access(1'b0, DEV_ADDR_OFFSET, '0);
    endtask

    // One random frame: mostly well formed, the rest damaged in one way or plain noise.
    task automatic send_random_frame();
        int         kind;
        int         pos;
        logic [7:0] b;
        logic [4:0] nib;
        kind = $urandom_range(99);
        build_frame(value_t'($urandom()));
        if (kind < 55) begin
        end else if (kind < 63) begin
            pos = $urandom_range(13, 12);
            nib = hex_value(frame_buf[pos]);
            frame_buf[pos] = hex_char(nib[3:0] + 4'($urandom_range(15, 1)));
        end else if (kind < 70) begin
            pos = $urandom_range(13, 6);
            do b = 8'($urandom_range(255)); while (hex_value(b) < 5'd16);
            frame_buf[pos] = b;
        end else if (kind < 77) begin
            pos = $urandom_range(7);
            if (pos >= 6) pos = pos + 8;
            b = 8'($urandom_range(255));
            if (b == frame_buf[pos]) b = ~b;
            frame_buf[pos] = b;
        end else if (kind < 84) begin
            pos = $urandom_range(15, 1);
            while (frame_buf.size() > pos) void'(frame_buf.pop_back());
        end else if (kind < 90) begin
            repeat ($urandom_range(24, 1)) frame_buf.push_back(8'($urandom_range(255)));
        end else begin
            frame_buf.delete();
            repeat ($urandom_range(20, 1)) frame_buf.push_back(8'($urandom_range(255)));
        end
        send_frame();
    endtask

    // Good frames at the address left by reset, with the value extremes.
    task automatic test_reset_address();
        build_frame(24'h000000);
        send_frame();
        build_frame(24'hFFFFFF);
        send_frame();
        build_frame(24'h5A3C96);
        send_frame();
    endtask

    // Each status code, and the order in which they take precedence.
    task automatic test_status_priority();
        // A short frame with a broken header still counts as wrong length.
        build_frame(24'h123456);
        frame_buf[0] = "#";
        while (frame_buf.size() > 5) void'(frame_buf.pop_back());
        send_frame();
        send_byte(ahrfp_pkg::CHAR_STAR, 1'b1);
        // Layout error together with a non-hex digit.
        build_frame(24'hABCDEF);
        frame_buf[1] = "c";
        frame_buf[8] = "G";
        send_frame();
        // Non-hex digits just outside the digit ranges, checksum off as well.
        build_frame(24'h13579B);
        frame_buf[10] = ":";
        send_frame();
        build_frame(24'h13579B);
        frame_buf[6] = "@";
        frame_buf[7] = "g";
        send_frame();
        build_frame(24'h13579B);
        frame_buf[13] = "/";
        send_frame();
        // Checksum wrong on its own.
        build_frame(24'h2468AC);
        frame_buf[13] = (frame_buf[13] == "0") ? 8'("1") : 8'("0");
        send_frame();
        // Terminators swapped, and a wrong address digit.
        build_frame(24'h777777);
        frame_buf[15] = ahrfp_pkg::CHAR_CR;
        send_frame();
        build_frame(24'h777777);
        frame_buf[14] = ahrfp_pkg::CHAR_LF;
        send_frame();
        build_frame(24'h808080);
        frame_buf[5] = frame_buf[5] + 8'd1;
        send_frame();
        // One byte too many, then far past the point where the count saturates.
        build_frame(24'h314159);
        frame_buf.push_back(ahrfp_pkg::CHAR_LF);
        send_frame();
        build_frame(24'h314159);
        repeat (24) frame_buf.push_back(8'($urandom_range(255)));
        send_frame();
        // A clean frame afterwards shows that the frame state was cleared.
        build_frame(24'h0F1E2D);
        send_frame();
    endtask

    // Address extremes, a tens digit beyond nine, upper data bits and an unused offset.
    task automatic test_address_extremes();
        set_address(DEV_ADDR_OFFSET, 32'd99);
        build_frame(24'h99AA55);
        send_frame();
        set_address(DEV_ADDR_OFFSET, 32'hFFFF_FFFF);
        build_frame(24'hC0FFEE);
        send_frame();
        build_frame(24'hC0FFEE);
        frame_buf[4] = "9";
        send_frame();
        set_address(DEV_ADDR_OFFSET, 32'hFFFF_FF80 | 32'd42);
        build_frame(24'h424242);
        send_frame();
        set_address(SPARE_OFFSET, 32'd7);
        build_frame(24'h0000FF);
        send_frame();
        set_address(DEV_ADDR_OFFSET, 32'd0);
        build_frame(24'hFF0000);
        send_frame();
    endtask

    // Random frames over several random addresses, then a burst with no idling.
    task automatic test_random_frames();
        logic [31:0] data;
        for (int phase = 0; phase < 5; phase++) begin
            data = $urandom();
            data[ahrfp_pkg::ADDR_W-1:0] = ($urandom_range(3) == 0) ?
                                          addr_t'($urandom_range(127)) :
                                          addr_t'($urandom_range(99));
            set_address(DEV_ADDR_OFFSET, data);
            repeat (2) send_random_frame();
        end
        settle();
        idle_on = 1'b0;
        repeat (6) send_random_frame();
        settle();
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_address();
        test_status_priority();
        test_address_extremes();
        test_random_frames();
        settle();

        if (mismatches == 0) begin
            $display("** ascii_hex_reading_frame_parser: PASSED **");
        end else begin
            $display("** ascii_hex_reading_frame_parser: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
design/ahrfp_pkg.sv
design/ascii_hex_reading_frame_parser.sv
design/ahrfp_checker.sv
verif/testbench.sv
